### hw/rtl/tpct_pkg.sv
// Shared types and constants of the touch primary contact tracker.
package tpct_pkg;

    // Field widths fixed by the item format.
    localparam int ID_W  = 8;
    localparam int RAW_W = 12;
    localparam int POS_W = 9;

    // Nominal raw panel spans.
    localparam int unsigned RAW_SPAN_X = 1920;
    localparam int unsigned RAW_SPAN_Y = 1088;

    // Fixed-point reciprocal used by the coordinate scaler.
    // With 24 fraction bits the rounded-up factor gives the exact floor
    // for every 12-bit raw value and both spans.
    localparam int SCALE_FRAC   = 24;
    localparam int SCALE_MULT_W = SCALE_FRAC + 1;
    localparam int SCALE_PROD_W = RAW_W + SCALE_MULT_W;
    localparam int SCALE_Q_W    = SCALE_PROD_W - SCALE_FRAC;

    // Pointer event codes.
    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_MOVE = 2'd2
    } event_kind_t;

    // One pointer event as held in the output stage.
    typedef struct packed {
        event_kind_t        kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               last;
    } event_t;

endpackage

### hw/rtl/tpct_scale.sv
// Scales one raw coordinate to the output grid and clamps it.
module tpct_scale #(
    parameter int OUT_SIZE = 480,
    parameter int SPAN     = 1920
) (
    input  logic [tpct_pkg::RAW_W-1:0]        raw,
    output logic [$clog2(OUT_SIZE)-1:0]       scaled
);

    localparam int OW = $clog2(OUT_SIZE);

    // Rounded-up reciprocal of SPAN / OUT_SIZE in fixed point.
    localparam longint unsigned MULT_FULL =
        ((longint'(OUT_SIZE) << tpct_pkg::SCALE_FRAC) + longint'(SPAN) - 1) / longint'(SPAN);
    localparam logic [tpct_pkg::SCALE_MULT_W-1:0] MULT =
        tpct_pkg::SCALE_MULT_W'(MULT_FULL);
    localparam logic [tpct_pkg::SCALE_Q_W-1:0] LIMIT = tpct_pkg::SCALE_Q_W'(OUT_SIZE);
    localparam logic [OW-1:0] MAX_POS = OW'(OUT_SIZE - 1);

    logic [tpct_pkg::SCALE_PROD_W-1:0] prod;
    logic [tpct_pkg::SCALE_Q_W-1:0]    quot;

    // Multiply by the reciprocal; the integer part is the quotient.
    assign prod = tpct_pkg::SCALE_PROD_W'(raw) * tpct_pkg::SCALE_PROD_W'(MULT);
    assign quot = prod[tpct_pkg::SCALE_PROD_W-1:tpct_pkg::SCALE_FRAC];

    // Clamp to the last grid position.
    assign scaled = (quot >= LIMIT) ? MAX_POS : OW'(quot);

endmodule

### hw/rtl/touch_primary_contact_tracker_unit.sv
// Top level of the touch primary contact tracker.
//
// Input channel: one item per transfer (in_valid high, in_stall low). An item
// is a contact report (report_valid = 1) or an empty marker, and frame_end
// flags the last item of a sampling frame. Output channel: pointer events
// (down, up, move) of the single tracked primary contact, one per transfer
// (out_valid high, out_stall low); last_event marks the final event of a frame.
// Only items with frame_end set produce events, zero to two of them.
// An accepted item passes the input register, is scaled into the scaled item
// register and updates the slot table as it leaves that register, writing its
// events into the output buffer, from which they are shown at out_valid.
// Throughput: one item per cycle while the output takes its events. A frame end
// holds the table stage until the output buffer is empty or its last event is
// being taken; items without frame_end never wait on the output.
// The rate is set by the two-entry output buffer and the one-pass table stage.
// Reset clears the pipeline, the output buffer, all slots and the primary.
// While the receiver stalls, the current event holds; input is taken until a
// frame end waits in the scaled item register and the input register is full.
module touch_primary_contact_tracker_unit #(
    parameter int SLOTS      = 5,
    parameter int OUT_WIDTH  = 480,
    parameter int OUT_HEIGHT = 320
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          report_valid,
    input  logic [tpct_pkg::ID_W-1:0]     contact_id,
    input  logic [tpct_pkg::RAW_W-1:0]    raw_x,
    input  logic [tpct_pkg::RAW_W-1:0]    raw_y,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_kind,
    output logic [tpct_pkg::POS_W-1:0]    pos_x,
    output logic [tpct_pkg::POS_W-1:0]    pos_y,
    output logic                          last_event
);

    localparam int XW = $clog2(OUT_WIDTH);
    localparam int YW = $clog2(OUT_HEIGHT);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // Input register.
    logic                          s1_valid_reg;
    logic                          s1_report_reg;
    logic [tpct_pkg::ID_W-1:0]     s1_id_reg;
    logic [tpct_pkg::RAW_W-1:0]    s1_raw_x_reg;
    logic [tpct_pkg::RAW_W-1:0]    s1_raw_y_reg;
    logic                          s1_frame_end_reg;

    // Scaled item register.
    logic                          s2_valid_reg;
    logic                          s2_report_reg;
    logic [tpct_pkg::ID_W-1:0]     s2_id_reg;
    logic [XW-1:0]                 s2_x_reg;
    logic [YW-1:0]                 s2_y_reg;
    logic                          s2_frame_end_reg;

    logic [XW-1:0]                 scaled_x;
    logic [YW-1:0]                 scaled_y;

    // Tracker state.
    logic [SLOTS-1:0]                         slot_used_reg, slot_used_next;
    logic [SLOTS-1:0]                         slot_seen_reg, slot_seen_next;
    logic [SLOTS-1:0][tpct_pkg::ID_W-1:0]     slot_contact_reg, slot_contact_next;
    logic [SLOTS-1:0][XW-1:0]                 slot_x_reg, slot_x_next;
    logic [SLOTS-1:0][YW-1:0]                 slot_y_reg, slot_y_next;
    logic                                     primary_valid_reg, primary_valid_next;
    logic [IW-1:0]                            primary_index_reg, primary_index_next;
    logic                                     fwd_valid_reg, fwd_valid_next;
    logic [XW-1:0]                            fwd_x_reg, fwd_x_next;
    logic [YW-1:0]                            fwd_y_reg, fwd_y_next;
    logic                                     newest_valid_reg, newest_valid_next;
    logic [IW-1:0]                            newest_index_reg, newest_index_next;
    logic [CW-1:0]                            count_reg, count_next;

    // Table lookup results.
    logic                 match_hit;
    logic [IW-1:0]        match_idx;
    logic                 free_hit;
    logic [IW-1:0]        free_idx;
    logic                 slot_take;
    logic [IW-1:0]        slot_sel;
    logic [XW-1:0]        prim_x;
    logic [YW-1:0]        prim_y;

    // Events of the current item.
    tpct_pkg::event_t     ev0, ev1, ev_new;
    logic [1:0]           ev_count;

    // Output buffer.
    tpct_pkg::event_t     head_reg, tail_reg;
    logic [1:0]           out_count_reg;

    logic                 out_take;
    logic                 out_room;
    logic                 s2_fire;
    logic                 s1_move;

    // Coordinate scalers.
    tpct_scale #(
        .OUT_SIZE (OUT_WIDTH),
        .SPAN     (tpct_pkg::RAW_SPAN_X)
    ) u_scale_x (
        .raw    (s1_raw_x_reg),
        .scaled (scaled_x)
    );

    tpct_scale #(
        .OUT_SIZE (OUT_HEIGHT),
        .SPAN     (tpct_pkg::RAW_SPAN_Y)
    ) u_scale_y (
        .raw    (s1_raw_y_reg),
        .scaled (scaled_y)
    );

    // Pipeline flow control.
    assign out_valid = (out_count_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    assign out_room  = (out_count_reg == 2'd0) || ((out_count_reg == 2'd1) && out_take);
    assign s2_fire   = s2_valid_reg && (!s2_frame_end_reg || out_room);
    assign s1_move   = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign in_stall  = s1_valid_reg && !(!s2_valid_reg || s2_fire);

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (s2_fire)
                s2_valid_reg <= 1'b0;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_report_reg    <= report_valid;
            s1_id_reg        <= contact_id;
            s1_raw_x_reg     <= raw_x;
            s1_raw_y_reg     <= raw_y;
            s1_frame_end_reg <= frame_end;
        end
        if (s1_move)
        begin
            s2_report_reg    <= s1_report_reg;
            s2_id_reg        <= s1_id_reg;
            s2_x_reg         <= scaled_x;
            s2_y_reg         <= scaled_y;
            s2_frame_end_reg <= s1_frame_end_reg;
        end
    end

    // Slot search: first used slot with this id, and lowest free slot.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (slot_used_reg[s] && (slot_contact_reg[s] == s2_id_reg))
            begin
                match_hit = 1'b1;
                match_idx = IW'(s);
            end
            if (!slot_used_reg[s])
            begin
                free_hit = 1'b1;
                free_idx = IW'(s);
            end
        end
    end

    // Table update and event generation for the item in the scaled register.
    always_comb
    begin
        slot_used_next     = slot_used_reg;
        slot_seen_next     = slot_seen_reg;
        slot_contact_next  = slot_contact_reg;
        slot_x_next        = slot_x_reg;
        slot_y_next        = slot_y_reg;
        primary_valid_next = primary_valid_reg;
        primary_index_next = primary_index_reg;
        fwd_valid_next     = fwd_valid_reg;
        fwd_x_next         = fwd_x_reg;
        fwd_y_next         = fwd_y_reg;
        newest_valid_next  = newest_valid_reg;
        newest_index_next  = newest_index_reg;
        count_next         = count_reg;
        slot_take          = 1'b0;
        slot_sel           = '0;
        prim_x             = '0;
        prim_y             = '0;
        ev0                = '0;
        ev1                = '0;
        ev_new             = '0;
        ev_count           = 2'd0;

        // Store a report while the frame still has room for it.
        if (s2_report_reg && (count_reg < CW'(SLOTS)))
        begin
            count_next = count_reg + CW'(1);
            if (match_hit)
            begin
                slot_take = 1'b1;
                slot_sel  = match_idx;
            end
            else if (free_hit)
            begin
                slot_take                   = 1'b1;
                slot_sel                    = free_idx;
                slot_used_next[free_idx]    = 1'b1;
                slot_contact_next[free_idx] = s2_id_reg;
                newest_valid_next           = 1'b1;
                newest_index_next           = free_idx;
            end
            if (slot_take)
            begin
                slot_seen_next[slot_sel] = 1'b1;
                slot_x_next[slot_sel]    = s2_x_reg;
                slot_y_next[slot_sel]    = s2_y_reg;
            end
        end

        if (s2_frame_end_reg)
        begin
            // Losing the primary contact lifts the pointer.
            if (primary_valid_next && slot_used_next[primary_index_next]
                && !slot_seen_next[primary_index_next])
            begin
                ev_new.kind = tpct_pkg::EV_UP;
                ev_new.x    = tpct_pkg::POS_W'(fwd_x_next);
                ev_new.y    = tpct_pkg::POS_W'(fwd_y_next);
                ev_new.last = 1'b0;
                ev0         = ev_new;
                ev_count    = 2'd1;
                primary_valid_next = 1'b0;
                fwd_valid_next     = 1'b0;
            end
            slot_used_next = slot_used_next & slot_seen_next;

            // The newest contact takes over the pointer.
            if (newest_valid_next
                && !(primary_valid_next && (primary_index_next == newest_index_next)))
            begin
                if (primary_valid_next)
                begin
                    ev_new.kind = tpct_pkg::EV_UP;
                    ev_new.x    = tpct_pkg::POS_W'(fwd_x_next);
                    ev_new.y    = tpct_pkg::POS_W'(fwd_y_next);
                    ev_new.last = 1'b0;
                    ev0         = ev_new;
                    ev_count    = 2'd1;
                end
                primary_valid_next = 1'b1;
                primary_index_next = newest_index_next;
                fwd_valid_next     = 1'b0;
            end

            // Forward the primary position as down or move.
            if (primary_valid_next)
            begin
                prim_x = slot_x_next[primary_index_next];
                prim_y = slot_y_next[primary_index_next];
                if (!fwd_valid_next || (fwd_x_next != prim_x) || (fwd_y_next != prim_y))
                begin
                    ev_new.kind = fwd_valid_next ? tpct_pkg::EV_MOVE : tpct_pkg::EV_DOWN;
                    ev_new.x    = tpct_pkg::POS_W'(prim_x);
                    ev_new.y    = tpct_pkg::POS_W'(prim_y);
                    ev_new.last = 1'b0;
                    if (ev_count == 2'd0)
                        ev0 = ev_new;
                    else
                        ev1 = ev_new;
                    ev_count = ev_count + 2'd1;
                end
                fwd_valid_next = 1'b1;
                fwd_x_next     = prim_x;
                fwd_y_next     = prim_y;
            end

            // Start a fresh frame.
            slot_seen_next    = '0;
            newest_valid_next = 1'b0;
            newest_index_next = '0;
            count_next        = '0;

            // Flag the final event of the frame.
            if (ev_count == 2'd1)
                ev0.last = 1'b1;
            else if (ev_count == 2'd2)
                ev1.last = 1'b1;
        end
    end

    // Tracker control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg     <= '0;
            slot_seen_reg     <= '0;
            primary_valid_reg <= 1'b0;
            primary_index_reg <= '0;
            fwd_valid_reg     <= 1'b0;
            fwd_x_reg         <= '0;
            fwd_y_reg         <= '0;
            newest_valid_reg  <= 1'b0;
            newest_index_reg  <= '0;
            count_reg         <= '0;
        end
        else if (s2_fire)
        begin
            slot_used_reg     <= slot_used_next;
            slot_seen_reg     <= slot_seen_next;
            primary_valid_reg <= primary_valid_next;
            primary_index_reg <= primary_index_next;
            fwd_valid_reg     <= fwd_valid_next;
            fwd_x_reg         <= fwd_x_next;
            fwd_y_reg         <= fwd_y_next;
            newest_valid_reg  <= newest_valid_next;
            newest_index_reg  <= newest_index_next;
            count_reg         <= count_next;
        end
    end

    // Slot contents, written only when a slot is allocated or refreshed.
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            slot_contact_reg <= slot_contact_next;
            slot_x_reg       <= slot_x_next;
            slot_y_reg       <= slot_y_next;
        end
    end

    // Output buffer: head is shown, tail holds the second event of a pair.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_count_reg <= 2'd0;
        else if (s2_fire && (ev_count != 2'd0))
            out_count_reg <= ev_count;
        else if (out_take)
            out_count_reg <= out_count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && (ev_count != 2'd0))
        begin
            head_reg <= ev0;
            tail_reg <= ev1;
        end
        else if (out_take)
            head_reg <= tail_reg;
    end

    assign event_kind = head_reg.kind;
    assign pos_x      = head_reg.x;
    assign pos_y      = head_reg.y;
    assign last_event = head_reg.last;

endmodule

### hw/rtl/tpct_checker.sv
// Port-level checks of the touch primary contact tracker and their binding.
module tpct_checker #(
    parameter int OUT_WIDTH  = 480,
    parameter int OUT_HEIGHT = 320
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    event_kind,
    input logic [tpct_pkg::POS_W-1:0]    pos_x,
    input logic [tpct_pkg::POS_W-1:0]    pos_y,
    input logic                          last_event
);

    // A stalled event holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(pos_x)
            && $stable(pos_y) && $stable(last_event))
    else $error("stalled event changed");

    // Down and move always close a frame's events.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind != tpct_pkg::EV_UP) |-> last_event)
    else $error("down or move event not flagged last");

    // The second event of a pair follows right after the first transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_event |=> out_valid)
    else $error("second event of a frame missing");

    // Positions stay on the output grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(pos_x) < OUT_WIDTH) && (int'(pos_y) < OUT_HEIGHT))
    else $error("event position off the grid");

endmodule

bind touch_primary_contact_tracker_unit tpct_checker #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
) u_tpct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last_event (last_event)
);

### sim/tb_touch_primary_contact_tracker_unit.sv
// Self-checking testbench for the touch primary contact tracker with a built-in event predictor.
`timescale 1ns / 1ps

module tb_touch_primary_contact_tracker_unit;

    localparam int SLOTS      = 5;
    localparam int OUT_WIDTH  = 480;
    localparam int OUT_HEIGHT = 320;
    localparam int POOL       = 8;
    localparam int ID_W       = tpct_pkg::ID_W;
    localparam int RAW_W      = tpct_pkg::RAW_W;
    localparam int POS_W      = tpct_pkg::POS_W;

    // One input transfer as queued for the driver.
    typedef struct packed {
        bit             rv;
        bit [ID_W-1:0]  id;
        bit [RAW_W-1:0] x;
        bit [RAW_W-1:0] y;
        bit             fe;
    } touch_item_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               report_valid = 1'b0;
    logic [ID_W-1:0]    contact_id   = '0;
    logic [RAW_W-1:0]   raw_x        = '0;
    logic [RAW_W-1:0]   raw_y        = '0;
    logic               frame_end    = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [1:0]         event_kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               last_event;

    touch_item_t        item_queue[$];
    touch_item_t        held_item;
    tpct_pkg::event_t   pending_events[$];
    tpct_pkg::event_t   want;
    int                 items_taken    = 0;
    int                 items_total    = 0;
    int                 mismatch_count = 0;
    logic               steady;

    // Tracker image: slot table, primary pointer and forwarded position.
    bit             slot_busy[SLOTS];
    bit [ID_W-1:0]  slot_id[SLOTS];
    bit [POS_W-1:0] slot_x[SLOTS];
    bit [POS_W-1:0] slot_y[SLOTS];
    bit             slot_hit[SLOTS];
    bit             prim_ok;
    int             prim_slot;
    bit             fwd_ok;
    bit [POS_W-1:0] fwd_x;
    bit [POS_W-1:0] fwd_y;
    bit             new_ok;
    int             newest_slot;
    int             frame_reports;

    touch_primary_contact_tracker_unit #(
        .SLOTS      (SLOTS),
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .report_valid (report_valid),
        .contact_id   (contact_id),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last_event   (last_event)
    );

    always #2 clk = ~clk;

    // Both sides run without gaps for a stretch in the middle of the run.
    assign steady = (items_taken >= 450) && (items_taken < 750);

    // Scale a raw coordinate to the output grid and clamp it.
    function automatic bit [POS_W-1:0] scale_coord(input bit [RAW_W-1:0] raw,
                                                   input int unsigned size,
                                                   input int unsigned span);
        int unsigned v;
        v = (raw * size) / span;
        if (v >= size)
            v = size - 1;
        return v[POS_W-1:0];
    endfunction

    function automatic tpct_pkg::event_t make_event(input tpct_pkg::event_kind_t kind,
                                                    input bit [POS_W-1:0] x,
                                                    input bit [POS_W-1:0] y);
        tpct_pkg::event_t ev;
        ev.kind = kind;
        ev.x    = x;
        ev.y    = y;
        ev.last = 1'b0;
        return ev;
    endfunction

    // Update the tracker image with one accepted item and queue the events it causes.
    task automatic track_item(input touch_item_t it);
        bit [POS_W-1:0]   sx;
        bit [POS_W-1:0]   sy;
        int               hit;
        tpct_pkg::event_t frame_events[$];
        tpct_pkg::event_t ev;
        hit = -1;
        if (it.rv && frame_reports < SLOTS) begin
            frame_reports++;
            sx = scale_coord(it.x, OUT_WIDTH, tpct_pkg::RAW_SPAN_X);
            sy = scale_coord(it.y, OUT_HEIGHT, tpct_pkg::RAW_SPAN_Y);
            for (int s = 0; s < SLOTS; s++)
                if (hit < 0 && slot_busy[s] && slot_id[s] == it.id)
                    hit = s;
            if (hit < 0) begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && !slot_busy[s])
                        hit = s;
                if (hit >= 0) begin
                    slot_busy[hit] = 1'b1;
                    slot_id[hit]   = it.id;
                    new_ok         = 1'b1;
                    newest_slot    = hit;
                end
            end
            if (hit >= 0) begin
                slot_hit[hit] = 1'b1;
                slot_x[hit]   = sx;
                slot_y[hit]   = sy;
            end
        end
        if (it.fe) begin
            // Free the slots that went unreported; losing the primary lifts the pointer.
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_busy[s] && !slot_hit[s]) begin
                    if (prim_ok && prim_slot == s) begin
                        frame_events.push_back(make_event(tpct_pkg::EV_UP, fwd_x, fwd_y));
                        prim_ok = 1'b0;
                        fwd_ok  = 1'b0;
                    end
                    slot_busy[s] = 1'b0;
                end
            end
            // The newest contact of the frame takes over the pointer.
            if (new_ok && !(prim_ok && prim_slot == newest_slot)) begin
                if (prim_ok)
                    frame_events.push_back(make_event(tpct_pkg::EV_UP, fwd_x, fwd_y));
                prim_ok   = 1'b1;
                prim_slot = newest_slot;
                fwd_ok    = 1'b0;
            end
            // Forward the primary position as down or move.
            if (prim_ok) begin
                if (!fwd_ok)
                    frame_events.push_back(make_event(tpct_pkg::EV_DOWN, slot_x[prim_slot],
                                                      slot_y[prim_slot]));
                else if (fwd_x != slot_x[prim_slot] || fwd_y != slot_y[prim_slot])
                    frame_events.push_back(make_event(tpct_pkg::EV_MOVE, slot_x[prim_slot],
                                                      slot_y[prim_slot]));
                fwd_ok = 1'b1;
                fwd_x  = slot_x[prim_slot];
                fwd_y  = slot_y[prim_slot];
            end
            for (int s = 0; s < SLOTS; s++)
                slot_hit[s] = 1'b0;
            new_ok        = 1'b0;
            newest_slot   = 0;
            frame_reports = 0;
            for (int i = 0; i < frame_events.size(); i++) begin
                ev      = frame_events[i];
                ev.last = (i == frame_events.size() - 1);
                pending_events.push_back(ev);
            end
        end
    endtask

    task automatic add_item(input bit rv, input bit [ID_W-1:0] id,
                            input bit [RAW_W-1:0] x, input bit [RAW_W-1:0] y,
                            input bit fe);
        touch_item_t it;
        it.rv = rv;
        it.id = id;
        it.x  = x;
        it.y  = y;
        it.fe = fe;
        item_queue.push_back(it);
    endtask

    // Move a contact: hold still, jitter by up to three raw units, or jump anywhere.
    task automatic wander(inout int cx, inout int cy);
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            // Keep the previous position.
        end else if (r < 50) begin
            cx = cx + $urandom_range(6) - 3;
            cy = cy + $urandom_range(6) - 3;
            if (cx < 0) cx = 0;
            if (cy < 0) cy = 0;
            if (cx > 4095) cx = 4095;
            if (cy > 4095) cy = 4095;
        end else if (r < 85) begin
            cx = $urandom_range(1919);
            cy = $urandom_range(1087);
        end else begin
            cx = $urandom_range(4095);
            cy = $urandom_range(4095);
        end
    endtask

    // Random frames: persistent contacts with random motion, plus noise and broken frames.
    task automatic build_random_frames(input int target);
        bit [ID_W-1:0] pool_id[POOL];
        bit            active[POOL];
        bit            reported[POOL];
        int            last_x[POOL];
        int            last_y[POOL];
        int            made;
        int            frames;
        int            r;
        int            rot;
        int            i;
        int            n;
        int            j;
        int            total;
        int            last_i;
        bit            fresh;
        bit            dup;
        bit            trail;
        made   = 0;
        frames = 0;
        while (made < target) begin
            if (frames % 150 == 0) begin
                for (i = 0; i < POOL; i++) begin
                    do begin
                        pool_id[i] = ID_W'($urandom_range(255));
                        fresh      = 1'b1;
                        for (int k = 0; k < i; k++)
                            if (pool_id[k] == pool_id[i])
                                fresh = 1'b0;
                    end while (!fresh);
                    active[i] = 1'b0;
                    last_x[i] = $urandom_range(1919);
                    last_y[i] = $urandom_range(1087);
                end
            end
            frames++;
            r = $urandom_range(99);
            if (r < 8) begin
                // Empty marker inside a frame; the block ignores it.
                add_item(1'b0, ID_W'($urandom_range(255)), RAW_W'($urandom_range(4095)),
                         RAW_W'($urandom_range(4095)), 1'b0);
                made++;
            end else if (r < 14) begin
                add_item(1'b0, ID_W'($urandom_range(255)), RAW_W'($urandom_range(4095)),
                         RAW_W'($urandom_range(4095)), 1'b1);
                made++;
            end else if (r < 17) begin
                // Crowded frame of unrelated ids: overflow and a full table.
                n = $urandom_range(8, 6);
                for (j = 0; j < n; j++)
                    add_item(1'b1, ID_W'($urandom_range(255)), RAW_W'($urandom_range(4095)),
                             RAW_W'($urandom_range(4095)), j == n - 1);
                made += n;
            end else begin
                rot = $urandom_range(POOL - 1);
                n   = 0;
                for (int k = 0; k < POOL; k++) begin
                    i = (rot + k) % POOL;
                    reported[i] = active[i] ? ($urandom_range(99) < 85)
                                            : ($urandom_range(99) < 12);
                    active[i] = reported[i];
                    if (reported[i])
                        n++;
                end
                dup    = (n > 0) && ($urandom_range(99) < 6);
                trail  = (n == 0) || ($urandom_range(99) < 10);
                total  = n + dup;
                j      = 0;
                last_i = 0;
                for (int k = 0; k < POOL; k++) begin
                    i = (rot + k) % POOL;
                    if (reported[i]) begin
                        wander(last_x[i], last_y[i]);
                        add_item(1'b1, pool_id[i], RAW_W'(last_x[i]), RAW_W'(last_y[i]),
                                 (j == total - 1) && !trail);
                        j++;
                        last_i = i;
                    end
                end
                if (dup) begin
                    wander(last_x[last_i], last_y[last_i]);
                    add_item(1'b1, pool_id[last_i], RAW_W'(last_x[last_i]),
                             RAW_W'(last_y[last_i]), !trail);
                end
                if (trail)
                    add_item(1'b0, ID_W'($urandom_range(255)), RAW_W'($urandom_range(4095)),
                             RAW_W'($urandom_range(4095)), 1'b1);
                made += total + trail;
            end
        end
    endtask

    // Input driver: offer queued items, holding the payload while stalled.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                track_item(held_item);
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (item_queue.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
                    held_item     = item_queue.pop_front();
                    in_valid     <= 1'b1;
                    report_valid <= held_item.rv;
                    contact_id   <= held_item.id;
                    raw_x        <= held_item.x;
                    raw_y        <= held_item.y;
                    frame_end    <= held_item.fe;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check every event transfer against the oldest expectation.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event transfer: kind %0d x %0d y %0d last %0d",
                           event_kind, pos_x, pos_y, last_event);
                    mismatch_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
                        mismatch_count++;
                    end
                    if (pos_x !== want.x) begin
                        $error("pos_x: expected %0d, actual %0d", want.x, pos_x);
                        mismatch_count++;
                    end
                    if (pos_y !== want.y) begin
                        $error("pos_y: expected %0d, actual %0d", want.y, pos_y);
                        mismatch_count++;
                    end
                    if (last_event !== want.last) begin
                        $error("last_event: expected %0d, actual %0d", want.last, last_event);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 11);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_busy[s] = 1'b0;
            slot_id[s]   = '0;
            slot_x[s]    = '0;
            slot_y[s]    = '0;
            slot_hit[s]  = 1'b0;
        end
        prim_ok       = 1'b0;
        prim_slot     = 0;
        fwd_ok        = 1'b0;
        fwd_x         = '0;
        fwd_y         = '0;
        new_ok        = 1'b0;
        newest_slot   = 0;
        frame_reports = 0;

        // Frame end with nothing tracked.
        add_item(1'b0, 8'h00, 12'd0, 12'd0, 1'b1);
        // First contact goes down at the origin, then holds still.
        add_item(1'b1, 8'h00, 12'd0, 12'd0, 1'b1);
        add_item(1'b1, 8'h00, 12'd0, 12'd0, 1'b1);
        // Move to the far corner, then clamp to the same position.
        add_item(1'b1, 8'h00, 12'd1919, 12'd1087, 1'b1);
        add_item(1'b1, 8'h00, 12'hFFF, 12'hFFF, 1'b1);
        // Empty marker without frame end.
        add_item(1'b0, 8'hFF, 12'hFFF, 12'hFFF, 1'b0);
        // A new contact pre-empts the primary: up then down.
        add_item(1'b1, 8'h00, 12'd960, 12'd544, 1'b0);
        add_item(1'b1, 8'hFF, 12'd4, 12'd4, 1'b1);
        // Six reports in one frame; the last one is beyond the table.
        add_item(1'b1, 8'h00, 12'd100, 12'd200, 1'b0);
        add_item(1'b1, 8'hFF, 12'd300, 12'd400, 1'b0);
        add_item(1'b1, 8'h55, 12'd500, 12'd600, 1'b0);
        add_item(1'b1, 8'hAA, 12'd700, 12'd800, 1'b0);
        add_item(1'b1, 8'h0F, 12'd900, 12'd1000, 1'b0);
        add_item(1'b1, 8'hF0, 12'd1100, 12'd1050, 1'b1);
        // New id with no free slot, then the others are freed.
        add_item(1'b1, 8'h33, 12'd1500, 12'd300, 1'b0);
        add_item(1'b1, 8'h0F, 12'd1200, 12'd700, 1'b1);
        // Repeated id in one frame; the later position wins.
        add_item(1'b1, 8'h0F, 12'd100, 12'd100, 1'b0);
        add_item(1'b1, 8'h0F, 12'd200, 12'd200, 1'b1);
        // The primary lifts while a new contact lands.
        add_item(1'b1, 8'h77, 12'd1700, 12'd900, 1'b1);
        // Empty frame releases everything.
        add_item(1'b0, 8'h00, 12'd0, 12'd0, 1'b1);

        build_random_frames(1250);
        items_total = item_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_total)
            @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
